// ===== hdl/tptlv_pkg.sv =====
// Package: shared types, constants and item kind codes for the TLV parser.
`timescale 1ns / 1ps
`default_nettype none
package tptlv_pkg;

  localparam logic [15:0] DefMaxPacket = 16'd1452;
  localparam logic [4:0]  DefAckExp    = 5'd3;
  localparam logic [5:0]  DefVerCap    = 6'd63;
  localparam int unsigned DefQueueDepth = 4;

  localparam logic [1:0] CfgRole   = 2'd0;
  localparam logic [1:0] CfgMaxPkt = 2'd1;
  localparam logic [1:0] CfgAckExp = 2'd2;
  localparam logic [1:0] CfgVerCap = 2'd3;

  localparam logic [3:0] KindVersion  = 4'd0;
  localparam logic [3:0] KindVerEntry = 4'd1;
  localparam logic [3:0] KindStrData  = 4'd2;
  localparam logic [3:0] KindData     = 4'd3;
  localparam logic [3:0] KindBidi     = 4'd4;
  localparam logic [3:0] KindUni      = 4'd5;
  localparam logic [3:0] KindIdle     = 4'd6;
  localparam logic [3:0] KindPacket   = 4'd7;
  localparam logic [3:0] KindExponent = 4'd8;
  localparam logic [3:0] KindTokenHi  = 4'd9;
  localparam logic [3:0] KindTokenLo  = 4'd10;
  localparam logic [3:0] KindStatus   = 4'd11;

  // One entry between front and back: optional value item plus optional status.
  typedef struct packed {
    logic        has_val;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        has_stat;
    logic        rejected;
    logic [15:0] eff_pkt;
    logic [7:0]  eff_exp;
  } ent_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        rejected;
    logic [15:0] eff_pkt;
    logic [7:0]  eff_exp;
    logic        final_flag;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/tptlv_ram.sv =====
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tptlv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/tptlv_front.sv =====
// Front: byte parser state machine, produces at most one queue entry per byte.
`timescale 1ns / 1ps
`default_nettype none
module tptlv_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 end_of_block_i,
  input  wire logic                 server_i,
  input  wire logic [15:0]          def_pkt_i,
  input  wire logic [4:0]           def_exp_i,
  input  wire logic [5:0]           ver_cap_i,
  output tptlv_pkg::ent_t           ent_o,
  output logic                      ent_used_o
);
  import tptlv_pkg::*;

  localparam logic [3:0] PhVer = 4'd0, PhVlen = 4'd1, PhVlist = 4'd2, PhSize = 4'd3,
                         PhRhdr = 4'd4, PhValue = 4'd5, PhSkip = 4'd6, PhDone = 4'd7,
                         PhErr = 4'd8;

  logic [3:0]  ph_q, ph_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [15:0] left_q, left_d, rid_q, rid_d, rlen_q, rlen_d;
  logic [63:0] sh_q, sh_d;
  logic [4:0]  fcnt_q, fcnt_d;
  logic [7:0]  seen_q, seen_d;
  logic [5:0]  vleft_q, vleft_d;
  logic        err_q, err_d;
  logic [15:0] rxpkt_q, rxpkt_d;
  logic [7:0]  rxexp_q, rxexp_d;

  function automatic logic [7:0] seen_bit(input logic [15:0] id);
    logic [7:0] r;
    r = 8'h00;
    unique case (id)
      16'd0: r = 8'h01;
      16'd1: r = 8'h02;
      16'd2: r = 8'h04;
      16'd3: r = 8'h08;
      16'd5: r = 8'h10;
      16'd6: r = 8'h20;
      16'd7: r = 8'h40;
      16'd8: r = 8'h80;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic [63:0] sh_in, v4;
  logic [15:0] lft_dec, id_n, len_n, need;
  logic        skip, forbid;
  logic [2:0]  hinc;
  logic [4:0]  finc;
  logic        ok;

  // next-record decision using a given bytes-left value
  function automatic logic [3:0] nr_phase(input logic srv, input logic [15:0] l);
    if (srv) begin
      if (l == 16'd0) return PhDone;
      else if (l < 16'd4) return PhErr;
      else return PhRhdr;
    end
    return (l < 16'd4) ? PhDone : PhRhdr;
  endfunction

  always_comb begin
    ent_o = '0;
    ph_d = ph_q; hcnt_d = hcnt_q; left_d = left_q; rid_d = rid_q; rlen_d = rlen_q;
    sh_d = sh_q; fcnt_d = fcnt_q; seen_d = seen_q; vleft_d = vleft_q; err_d = err_q;
    rxpkt_d = rxpkt_q; rxexp_d = rxexp_q;
    sh_in = {sh_q[55:0], data_byte_i};
    v4 = {sh_in[61:0], 2'b00};
    lft_dec = left_q - 16'd1;
    hinc = hcnt_q + 3'd1;
    finc = fcnt_q + 5'd1;
    id_n = sh_in[31:16];
    len_n = sh_in[15:0];
    need = 16'd0; skip = 1'b0; forbid = 1'b0;
    unique case (id_n)
      16'd0, 16'd1: need = 16'd4;
      16'd2, 16'd3, 16'd5, 16'd8: need = 16'd2;
      16'd7: need = 16'd1;
      16'd6: begin need = 16'd16; forbid = !server_i; end
      16'd4: begin skip = 1'b1; forbid = !server_i; end
      default: skip = 1'b1;
    endcase
    unique case (ph_q)
      PhVer: begin
        sh_d = sh_in; hcnt_d = hinc;
        if (hinc == 3'd4) begin
          ent_o.has_val = 1'b1; ent_o.kind = KindVersion;
          ent_o.value = {32'd0, sh_in[31:0]};
          sh_d = '0; hcnt_d = '0; ph_d = server_i ? PhVlen : PhSize;
        end
      end
      PhVlen: begin
        if (data_byte_i < 8'd4 || data_byte_i[1:0] != 2'd0 ||
            data_byte_i[7:2] > ver_cap_i) begin
          err_d = 1'b1; ph_d = PhErr;
        end else begin
          vleft_d = data_byte_i[7:2]; hcnt_d = '0; sh_d = '0; ph_d = PhVlist;
        end
      end
      PhVlist: begin
        sh_d = sh_in; hcnt_d = hinc;
        if (hinc == 3'd4) begin
          ent_o.has_val = 1'b1; ent_o.kind = KindVerEntry;
          ent_o.value = {32'd0, sh_in[31:0]};
          sh_d = '0; hcnt_d = '0;
          vleft_d = (vleft_q != 6'd0) ? vleft_q - 6'd1 : 6'd0;
          if (vleft_d == 6'd0) ph_d = PhSize;
        end
      end
      PhSize: begin
        sh_d = sh_in; hcnt_d = hinc;
        if (hinc == 3'd2) begin
          if (server_i ? (sh_in[15:0] < 16'd4) : (sh_in[15:0] < 16'd22)) begin
            err_d = 1'b1; ph_d = PhErr;
          end else begin
            left_d = sh_in[15:0];
            hcnt_d = '0; fcnt_d = '0; sh_d = '0;
            ph_d = nr_phase(server_i, sh_in[15:0]);
            err_d = (ph_d == PhErr);
          end
        end
      end
      PhRhdr: begin
        sh_d = sh_in; left_d = lft_dec; hcnt_d = hinc;
        if (hinc == 3'd4) begin
          rid_d = id_n; rlen_d = len_n; hcnt_d = '0;
          if (len_n > lft_dec || forbid) begin
            err_d = 1'b1; ph_d = PhErr;
          end else if (skip) begin
            if (len_n == 16'd0) begin
              fcnt_d = '0; sh_d = '0;
              ph_d = nr_phase(server_i, lft_dec); err_d = (ph_d == PhErr);
            end else ph_d = PhSkip;
          end else if (len_n != need || (seen_q & seen_bit(id_n)) != 8'h00) begin
            err_d = 1'b1; ph_d = PhErr;
          end else begin
            fcnt_d = '0; sh_d = '0; ph_d = PhValue;
          end
        end
      end
      PhValue: begin
        sh_d = sh_in; left_d = lft_dec; fcnt_d = finc;
        if (rid_q == 16'd6) begin
          if (finc == 5'd8) begin
            ent_o.has_val = 1'b1; ent_o.kind = KindTokenHi; ent_o.value = sh_in;
            sh_d = '0;
          end else if (finc >= 5'd16) begin
            ent_o.has_val = 1'b1; ent_o.kind = KindTokenLo; ent_o.value = sh_in;
            seen_d = seen_q | 8'h20;
            hcnt_d = '0; fcnt_d = '0; sh_d = '0;
            ph_d = nr_phase(server_i, lft_dec); err_d = (ph_d == PhErr);
          end
        end else if ({11'd0, finc} >= rlen_q) begin
          seen_d = seen_q | seen_bit(rid_q);
          ent_o.value = sh_in; ent_o.has_val = 1'b1;
          hcnt_d = '0; fcnt_d = '0; sh_d = '0;
          ph_d = nr_phase(server_i, lft_dec); err_d = (ph_d == PhErr);
          case (rid_q)
            16'd0: ent_o.kind = KindStrData;
            16'd1: ent_o.kind = KindData;
            16'd2: begin
              ent_o.kind = KindBidi;
              if (server_i) ent_o.value = (sh_in != 0) ? v4 - 64'd3 : 64'd0;
              else ent_o.value = v4;
            end
            16'd8: begin
              ent_o.kind = KindUni;
              if (sh_in == 0) ent_o.value = 64'd0;
              else ent_o.value = server_i ? v4 - 64'd1 : v4 - 64'd2;
            end
            16'd3: ent_o.kind = KindIdle;
            16'd5: begin
              ent_o.kind = KindPacket; rxpkt_d = sh_in[15:0];
              if (sh_in < 64'd1200) begin
                ent_o.has_val = 1'b0; err_d = 1'b1; ph_d = PhErr;
              end
            end
            16'd7: begin
              ent_o.kind = KindExponent; rxexp_d = sh_in[7:0];
              if (sh_in > 64'd20) begin
                ent_o.has_val = 1'b0; err_d = 1'b1; ph_d = PhErr;
              end
            end
            default: ent_o.has_val = 1'b0;
          endcase
        end
      end
      PhSkip: begin
        left_d = lft_dec; rlen_d = rlen_q - 16'd1;
        if (rlen_d == 16'd0) begin
          hcnt_d = '0; fcnt_d = '0; sh_d = '0;
          ph_d = nr_phase(server_i, lft_dec); err_d = (ph_d == PhErr);
        end
      end
      default: ;
    endcase
    ok = !err_d && ph_d == PhDone && (seen_d & 8'h0B) == 8'h0B;
    if (end_of_block_i) begin
      ent_o.has_stat = 1'b1;
      ent_o.rejected = !ok;
      ent_o.eff_pkt = seen_d[4] ? rxpkt_d : def_pkt_i;
      ent_o.eff_exp = seen_d[6] ? rxexp_d : {3'd0, def_exp_i};
      ph_d = PhVer; hcnt_d = '0; left_d = '0; rid_d = '0; rlen_d = '0; sh_d = '0;
      fcnt_d = '0; seen_d = '0; vleft_d = '0; err_d = 1'b0; rxpkt_d = '0; rxexp_d = '0;
    end
    ent_used_o = ent_o.has_val | ent_o.has_stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhVer; hcnt_q <= '0; left_q <= '0; rid_q <= '0; rlen_q <= '0;
      sh_q <= '0; fcnt_q <= '0; seen_q <= '0; vleft_q <= '0; err_q <= 1'b0;
      rxpkt_q <= '0; rxexp_q <= '0;
    end else if (step_i) begin
      ph_q <= ph_d; hcnt_q <= hcnt_d; left_q <= left_d; rid_q <= rid_d;
      rlen_q <= rlen_d; sh_q <= sh_d; fcnt_q <= fcnt_d; seen_q <= seen_d;
      vleft_q <= vleft_d; err_q <= err_d; rxpkt_q <= rxpkt_d; rxexp_q <= rxexp_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tptlv_back.sv =====
// Back: entry queue in RAM and result unpacking into up to two items.
`timescale 1ns / 1ps
`default_nettype none
module tptlv_back #(
  parameter int unsigned Depth = tptlv_pkg::DefQueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  tptlv_pkg::ent_t      ent_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output tptlv_pkg::res_t      res_o
);
  import tptlv_pkg::*;
  localparam int unsigned Aw = $clog2(Depth);
  localparam int unsigned Ew = $bits(ent_t);

  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;
  logic          ram_v_q, hold_v_q;   // ram read valid, holding stage valid
  ent_t          hold_q, ram_q;
  logic          half_q;              // value part already delivered
  logic          rd, take, pop_ok, ram_take, last_part;
  logic [Ew-1:0] rdata;
  logic [Aw-1:0] raddr, rp_prev;

  // a pending read that is not taken re-reads its own address, so the data holds
  assign rp_prev = (rp_q == '0) ? Aw'(Depth-1) : rp_q - Aw'(1);
  assign raddr   = rd ? rp_q : rp_prev;

  tptlv_ram #(.Width(Ew), .Depth(Depth)) u_ram (
    .clk_i, .we_i(push_i), .waddr_i(wp_q), .wdata_i(ent_i),
    .raddr_i(raddr), .rdata_o(rdata)
  );
  assign ram_q = ent_t'(rdata);

  assign full_o  = cnt_q == (Aw+1)'(Depth);
  assign empty_o = !hold_v_q;
  assign pop_ok  = pop_i && hold_v_q;
  assign last_part = !(hold_q.has_val && hold_q.has_stat && !half_q);
  assign take = !hold_v_q || (pop_ok && last_part);
  assign ram_take = ram_v_q && take;
  // keep at most one read in flight; the count still holds the entry being read
  assign rd = (cnt_q != (Aw+1)'(ram_v_q)) && (!ram_v_q || ram_take);

  always_comb begin
    res_o = '0;
    if (hold_q.has_val && !half_q) begin
      res_o.kind = hold_q.kind; res_o.value = hold_q.value;
    end else begin
      res_o.kind = KindStatus; res_o.rejected = hold_q.rejected;
      res_o.eff_pkt = hold_q.eff_pkt; res_o.eff_exp = hold_q.eff_exp;
      res_o.final_flag = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; ram_v_q <= 1'b0; hold_v_q <= 1'b0;
      half_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + Aw'(1);
      if (rd) rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(ram_take);
      if (rd) ram_v_q <= 1'b1;
      else if (ram_take) ram_v_q <= 1'b0;
      if (pop_ok && !last_part) half_q <= 1'b1;
      if (take) begin
        hold_v_q <= ram_v_q; half_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_take) hold_q <= ram_q;
  end
endmodule
`default_nettype wire

// ===== hdl/transport_param_tlv_parser_top.sv =====
// Top level: transport-parameter TLV parser with queue-style ports.
// Results pass through the queue RAM, its registered read and a holding stage.
// Throughput: one byte per cycle while full is low; a byte giving both a value
// and a status item holds the result side for two pops.
// Reset (rst_ni low, asynchronous) clears parser state and queue and returns config to its defaults.
// full is held high while the entry queue cannot take another entry.
`timescale 1ns / 1ps
`default_nettype none
module transport_param_tlv_parser_top #(
  parameter int unsigned QueueDepth = tptlv_pkg::DefQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_block_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       item_kind_o,
  output logic [63:0]      item_value_o,
  output logic             parse_status_o,
  output logic [15:0]      effective_max_packet_o,
  output logic [7:0]       effective_ack_exponent_o,
  output logic             final_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import tptlv_pkg::*;

  logic        srv_q;
  logic [15:0] pkt_q;
  logic [4:0]  exp_q;
  logic [5:0]  cap_q;
  ent_t        ent;
  res_t        res;
  logic        used, step, qfull;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_q <= 1'b0; pkt_q <= DefMaxPacket; exp_q <= DefAckExp; cap_q <= DefVerCap;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRole:   srv_q <= cfg_data_i[0];
        CfgMaxPkt: pkt_q <= cfg_data_i;
        CfgAckExp: exp_q <= cfg_data_i[4:0];
        CfgVerCap: cap_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // a byte is taken only when the queue has room for whatever it yields
  assign full = qfull;
  assign step = push && !qfull;

  tptlv_front u_front (
    .clk_i, .rst_ni, .step_i(step), .data_byte_i, .end_of_block_i,
    .server_i(srv_q), .def_pkt_i(pkt_q), .def_exp_i(exp_q), .ver_cap_i(cap_q),
    .ent_o(ent), .ent_used_o(used)
  );

  tptlv_back #(.Depth(QueueDepth)) u_back (
    .clk_i, .rst_ni, .push_i(step && used), .ent_i(ent), .full_o(qfull),
    .pop_i(pop), .empty_o(empty), .res_o(res)
  );

  assign item_kind_o              = res.kind;
  assign item_value_o             = res.value;
  assign parse_status_o           = res.rejected;
  assign effective_max_packet_o   = res.eff_pkt;
  assign effective_ack_exponent_o = res.eff_exp;
  assign final_item_o             = res.final_flag;
endmodule
`default_nettype wire

// ===== hdl/tptlv_checker.sv =====
// Port-level checker for the TLV parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tptlv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [3:0]  item_kind_o,
  input wire logic [63:0] item_value_o,
  input wire logic        final_item_o,
  input wire logic        parse_status_o
);
  import tptlv_pkg::*;
  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (final_item_o == (item_kind_o == KindStatus)))
    else $error("final flag and status kind disagree");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && final_item_o) |-> (item_value_o == 64'd0))
    else $error("status item carries a value");
  a_nonstat_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !final_item_o) |-> !parse_status_o)
    else $error("value item flags rejection");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(item_kind_o)))
    else $error("waiting item changed");
endmodule

bind transport_param_tlv_parser_top tptlv_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .item_kind_o, .item_value_o, .final_item_o,
  .parse_status_o
);
`default_nettype wire
